// File: rtl/gctb_pkg.sv
// ----------------------------------------------------------------------------
// gctb_pkg: shared types and constants
// Field widths, item kinds, register indexes and the controller/datapath
// command and status structs of the gradient color table builder.
// ----------------------------------------------------------------------------
package gctb_pkg;

  localparam int unsigned DEF_MAX_STOPS = 16;
  localparam int unsigned RAMP_ENTRIES  = 256;
  localparam int unsigned TBL_DEPTH     = 2 * RAMP_ENTRIES;
  localparam int unsigned TBL_AW        = $clog2(TBL_DEPTH);

  localparam int unsigned CH_W      = 8;
  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned COL_W     = NUM_LANES * CH_W;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CNT_W     = 5;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_STOP_WR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BUILD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFLECT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP       = 2'd2;

  // table write data source
  typedef enum logic [1:0] {
    WSRC_ZERO,
    WSRC_STOP,
    WSRC_INTERP
  } wsrc_e;

  typedef struct packed {
    logic              stop_wr;
    logic              stop_rd;
    logic              load_a;
    logic              div_start;
    logic              interp_step;
    logic              tbl_wr;
    logic [TBL_AW-1:0] tbl_wr_addr;
    wsrc_e             tbl_wr_src;
    logic              item_rd;
    logic              refl_rd;
    logic [TBL_AW-1:0] tbl_rd_addr;
  } dp_cmd_t;

  typedef struct packed {
    logic [POS_W-1:0] a_pos;
    logic [POS_W-1:0] b_pos;
    logic             rising;
    logic             div_busy;
    logic             s1_free;
    logic             s1_empty;
    logic             reflect;
  } dp_sts_t;

endpackage

// File: rtl/gctb_if.sv
// ----------------------------------------------------------------------------
// gctb_if: item channels
// Valid/ready channels for command items and table entry results.
// ----------------------------------------------------------------------------
interface gctb_in_if;
  import gctb_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [SLOT_W-1:0]   stop_slot;
  logic [POS_W-1:0]    stop_position;
  logic [CH_W-1:0]     stop_alpha;
  logic [CH_W-1:0]     stop_chan0;
  logic [CH_W-1:0]     stop_chan1;
  logic [CH_W-1:0]     stop_chan2;
  logic [TBL_AW-1:0]   read_index;

  modport source (
    output valid, kind, stop_slot, stop_position, stop_alpha, stop_chan0,
           stop_chan1, stop_chan2, read_index,
    input  ready
  );
  modport sink (
    input  valid, kind, stop_slot, stop_position, stop_alpha, stop_chan0,
           stop_chan1, stop_chan2, read_index,
    output ready
  );
endinterface

interface gctb_out_if;
  import gctb_pkg::*;

  logic              valid;
  logic              ready;
  logic [TBL_AW-1:0] entry_index;
  logic [CH_W-1:0]   entry_alpha;
  logic [CH_W-1:0]   entry_chan0;
  logic [CH_W-1:0]   entry_chan1;
  logic [CH_W-1:0]   entry_chan2;

  modport source (
    output valid, entry_index, entry_alpha, entry_chan0, entry_chan1, entry_chan2,
    input  ready
  );
  modport sink (
    input  valid, entry_index, entry_alpha, entry_chan0, entry_chan1, entry_chan2,
    output ready
  );
endinterface

// File: rtl/gctb_div.sv
// ----------------------------------------------------------------------------
// gctb_div: four-lane restoring divider
// Unsigned 8-bit divide of each lane by a shared divisor, one quotient bit
// per cycle. Quotient and remainder hold after busy drops.
// ----------------------------------------------------------------------------
module gctb_div (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          start_i,
  input  logic [gctb_pkg::NUM_LANES-1:0][gctb_pkg::CH_W-1:0] dividend_i,
  input  logic [gctb_pkg::CH_W-1:0]                     divisor_i,
  output logic                                          busy_o,
  output logic [gctb_pkg::NUM_LANES-1:0][gctb_pkg::CH_W-1:0] quo_o,
  output logic [gctb_pkg::NUM_LANES-1:0][gctb_pkg::CH_W-1:0] rem_o
);
  import gctb_pkg::*;

  localparam int unsigned STEP_W = $clog2(CH_W);

  logic                               busy_q;
  logic [STEP_W-1:0]                  step_q;
  logic [CH_W-1:0]                    dvs_q;
  logic [NUM_LANES-1:0][CH_W-1:0]     quo_q, quo_d, rem_q, rem_d;
  logic [NUM_LANES-1:0][CH_W:0]       rem_sh;
  logic [NUM_LANES-1:0]               fits;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      rem_sh[l] = {rem_q[l], quo_q[l][CH_W-1]};
      fits[l]   = (rem_sh[l] >= {1'b0, dvs_q});
      if (fits[l]) begin
        rem_d[l] = CH_W'(rem_sh[l] - {1'b0, dvs_q});
      end else begin
        rem_d[l] = rem_sh[l][CH_W-1:0];
      end
      quo_d[l] = {quo_q[l][CH_W-2:0], fits[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == STEP_W'(CH_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/gctb_dp.sv
// ----------------------------------------------------------------------------
// gctb_dp: datapath
// Config registers, stop memory, segment interpolator, ramp table memory
// and the two-stage read pipeline ending in the result register.
// ----------------------------------------------------------------------------
module gctb_dp #(
  parameter  int unsigned MAX_STOPS = gctb_pkg::DEF_MAX_STOPS,
  localparam int unsigned SW        = $clog2(MAX_STOPS),
  localparam int unsigned NW        = $clog2(MAX_STOPS + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gctb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [gctb_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [gctb_pkg::SLOT_W-1:0]       stop_slot_i,
  input  logic [gctb_pkg::POS_W-1:0]        stop_position_i,
  input  logic [gctb_pkg::CH_W-1:0]         stop_alpha_i,
  input  logic [gctb_pkg::CH_W-1:0]         stop_chan0_i,
  input  logic [gctb_pkg::CH_W-1:0]         stop_chan1_i,
  input  logic [gctb_pkg::CH_W-1:0]         stop_chan2_i,
  input  logic [gctb_pkg::TBL_AW-1:0]       read_index_i,
  input  gctb_pkg::dp_cmd_t                 cmd_i,
  input  logic [SW-1:0]                     stop_raddr_i,
  output gctb_pkg::dp_sts_t                 sts_o,
  output logic [NW-1:0]                     n_stops_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [gctb_pkg::TBL_AW-1:0]       entry_index_o,
  output logic [gctb_pkg::CH_W-1:0]         entry_alpha_o,
  output logic [gctb_pkg::CH_W-1:0]         entry_chan0_o,
  output logic [gctb_pkg::CH_W-1:0]         entry_chan1_o,
  output logic [gctb_pkg::CH_W-1:0]         entry_chan2_o
);
  import gctb_pkg::*;

  localparam int unsigned STOP_W = POS_W + COL_W;

  // configuration
  logic [CNT_W-1:0] stop_count_q;
  logic             reflect_q;
  logic             swap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_count_q <= '0;
      reflect_q    <= 1'b0;
      swap_q       <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STOP_COUNT: stop_count_q <= cfg_data_i[CNT_W-1:0];
        CFG_REFLECT:    reflect_q    <= cfg_data_i[0];
        CFG_SWAP:       swap_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign n_stops_o = (32'(stop_count_q) > MAX_STOPS) ? NW'(MAX_STOPS) : NW'(stop_count_q);

  // stop memory; entries never written read as zero
  logic [STOP_W-1:0]    stop_mem [MAX_STOPS];
  logic [MAX_STOPS-1:0] stop_vld_q;
  logic [STOP_W-1:0]    sd_q;
  logic                 sv_q;
  logic                 stop_we;
  logic [SW-1:0]        stop_waddr;

  assign stop_we    = cmd_i.stop_wr && (32'(stop_slot_i) < MAX_STOPS);
  assign stop_waddr = SW'(stop_slot_i);

  always_ff @(posedge clk_i) begin
    if (stop_we) begin
      stop_mem[stop_waddr] <= {stop_position_i, stop_alpha_i, stop_chan2_i,
                               stop_chan1_i, stop_chan0_i};
    end
    if (cmd_i.stop_rd) begin
      sd_q <= stop_mem[stop_raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_vld_q <= '0;
      sv_q       <= 1'b0;
    end else begin
      if (stop_we) begin
        stop_vld_q[stop_waddr] <= 1'b1;
      end
      if (cmd_i.stop_rd) begin
        sv_q <= stop_vld_q[stop_raddr_i];
      end
    end
  end

  logic [STOP_W-1:0] b_word;
  logic [POS_W-1:0]  b_pos;
  logic [COL_W-1:0]  b_col;

  assign b_word = sv_q ? sd_q : '0;
  assign b_pos  = b_word[STOP_W-1:COL_W];
  assign b_col  = b_word[COL_W-1:0];

  // segment start stop
  logic [POS_W-1:0] a_pos_q;
  logic [COL_W-1:0] a_col_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a) begin
      a_pos_q <= b_pos;
      a_col_q <= b_col;
    end
  end

  // per-lane |delta| / span, then a running quotient and remainder
  logic [NUM_LANES-1:0][CH_W:0]   dlt;
  logic [NUM_LANES-1:0][CH_W-1:0] mag;
  logic [CH_W-1:0]                span;
  logic                           div_busy;
  logic [NUM_LANES-1:0][CH_W-1:0] quo, rem;
  logic [NUM_LANES-1:0]           neg_q;
  logic [CH_W-1:0]                diff_q;
  logic [NUM_LANES-1:0][CH_W-1:0] q_q, r_q, q_nx, r_nx, val;
  logic [NUM_LANES-1:0][CH_W:0]   qsum, rsum;

  assign span = CH_W'(b_pos - a_pos_q);

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      dlt[l] = {1'b0, b_col[l*CH_W +: CH_W]} - {1'b0, a_col_q[l*CH_W +: CH_W]};
      mag[l] = dlt[l][CH_W] ? CH_W'(-dlt[l]) : dlt[l][CH_W-1:0];
      qsum[l] = {1'b0, q_q[l]} + {1'b0, quo[l]};
      rsum[l] = {1'b0, r_q[l]} + {1'b0, rem[l]};
      if (rsum[l] >= {1'b0, diff_q}) begin
        q_nx[l] = CH_W'(qsum[l] + 1'b1);
        r_nx[l] = CH_W'(rsum[l] - {1'b0, diff_q});
      end else begin
        q_nx[l] = qsum[l][CH_W-1:0];
        r_nx[l] = rsum[l][CH_W-1:0];
      end
      // truncation toward zero: negate the floor of the magnitude
      val[l] = neg_q[l] ? a_col_q[l*CH_W +: CH_W] - q_q[l]
                        : a_col_q[l*CH_W +: CH_W] + q_q[l];
    end
  end

  gctb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (mag),
    .divisor_i  (span),
    .busy_o     (div_busy),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        neg_q[l] <= dlt[l][CH_W];
      end
      diff_q <= span;
      q_q    <= '0;
      r_q    <= '0;
    end else if (cmd_i.interp_step) begin
      q_q <= q_nx;
      r_q <= r_nx;
    end
  end

  logic [COL_W-1:0] interp_word;

  // lanes: 0 chan0, 1 chan1, 2 chan2, 3 alpha
  assign interp_word = {val[3], swap_q ? val[0] : val[2], val[1],
                        swap_q ? val[2] : val[0]};

  // ramp table
  logic [COL_W-1:0]  ramp_mem [TBL_DEPTH];
  logic [COL_W-1:0]  rdata_q;
  logic              tbl_re;
  logic [TBL_AW-1:0] tbl_raddr;
  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_waddr;
  logic [COL_W-1:0]  tbl_wdata;
  logic              refl_wr_q;
  logic [TBL_AW-1:0] refl_waddr_q;

  assign tbl_re    = cmd_i.item_rd || cmd_i.refl_rd;
  assign tbl_raddr = cmd_i.item_rd ? read_index_i : cmd_i.tbl_rd_addr;

  always_comb begin
    tbl_we    = cmd_i.tbl_wr || refl_wr_q;
    tbl_waddr = cmd_i.tbl_wr_addr;
    case (cmd_i.tbl_wr_src)
      WSRC_STOP:   tbl_wdata = a_col_q;
      WSRC_INTERP: tbl_wdata = interp_word;
      default:     tbl_wdata = '0;
    endcase
    // mirrored half is written in the cycle after its source is read
    if (refl_wr_q) begin
      tbl_waddr = refl_waddr_q;
      tbl_wdata = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      ramp_mem[tbl_waddr] <= tbl_wdata;
    end
    if (tbl_re) begin
      rdata_q <= ramp_mem[tbl_raddr];
    end
    refl_waddr_q <= TBL_AW'(TBL_DEPTH - 1) - cmd_i.tbl_rd_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refl_wr_q <= 1'b0;
    end else begin
      refl_wr_q <= cmd_i.refl_rd;
    end
  end

  // read pipeline: table read stage, then result register
  logic              s1_v_q;
  logic [TBL_AW-1:0] s1_idx_q;
  logic              out_v_q;
  logic [TBL_AW-1:0] out_idx_q;
  logic [COL_W-1:0]  out_col_q;
  logic              out_adv;

  assign out_adv = s1_v_q && (!out_v_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (cmd_i.item_rd) begin
        s1_v_q <= 1'b1;
      end else if (out_adv) begin
        s1_v_q <= 1'b0;
      end
      if (out_adv) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_rd) begin
      s1_idx_q <= read_index_i;
    end
    if (out_adv) begin
      out_idx_q <= s1_idx_q;
      out_col_q <= rdata_q;
    end
  end

  assign out_valid_o   = out_v_q;
  assign entry_index_o = out_idx_q;
  assign entry_alpha_o = out_col_q[3*CH_W +: CH_W];
  assign entry_chan2_o = out_col_q[2*CH_W +: CH_W];
  assign entry_chan1_o = out_col_q[1*CH_W +: CH_W];
  assign entry_chan0_o = out_col_q[0 +: CH_W];

  always_comb begin
    sts_o          = '0;
    sts_o.a_pos    = a_pos_q;
    sts_o.b_pos    = b_pos;
    sts_o.rising   = (b_pos > a_pos_q);
    sts_o.div_busy = div_busy;
    sts_o.s1_free  = !s1_v_q || out_adv;
    sts_o.s1_empty = !s1_v_q;
    sts_o.reflect  = reflect_q;
  end

endmodule

// File: rtl/gctb_ctrl.sv
// ----------------------------------------------------------------------------
// gctb_ctrl: controller
// Accepts items and sequences a build: clear or stop-0 fill, segment
// interpolation, tail fill and mirror copy.
// ----------------------------------------------------------------------------
module gctb_ctrl #(
  parameter  int unsigned MAX_STOPS = gctb_pkg::DEF_MAX_STOPS,
  localparam int unsigned SW        = $clog2(MAX_STOPS),
  localparam int unsigned NW        = $clog2(MAX_STOPS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [gctb_pkg::KIND_W-1:0]   in_kind_i,
  output logic                          in_ready_o,
  input  gctb_pkg::dp_sts_t             sts_i,
  input  logic [NW-1:0]                 n_stops_i,
  output gctb_pkg::dp_cmd_t             cmd_o,
  output logic [SW-1:0]                 stop_raddr_o
);
  import gctb_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_CLEAR    = 4'd1;
  localparam logic [3:0] ST_LD0      = 4'd2;
  localparam logic [3:0] ST_LD0W     = 4'd3;
  localparam logic [3:0] ST_FILL0    = 4'd4;
  localparam logic [3:0] ST_SEG_RD   = 4'd5;
  localparam logic [3:0] ST_SEG_CHK  = 4'd6;
  localparam logic [3:0] ST_DIV      = 4'd7;
  localparam logic [3:0] ST_INTERP   = 4'd8;
  localparam logic [3:0] ST_TAIL     = 4'd9;
  localparam logic [3:0] ST_REFL     = 4'd10;
  localparam logic [3:0] ST_REFL_END = 4'd11;

  logic [3:0]        state_q, state_d;
  logic [TBL_AW-1:0] cnt_q, cnt_d;
  logic [TBL_AW-1:0] tail_q, tail_d;
  logic [NW-1:0]     k_q, k_d;
  logic              accept;
  logic [TBL_AW-1:0] clr_last;
  logic [TBL_AW-1:0] cnt_inc;
  logic [NW:0]       k_plus2;
  logic              more_segs;

  assign clr_last  = sts_i.reflect ? TBL_AW'(TBL_DEPTH - 1) : TBL_AW'(RAMP_ENTRIES - 1);
  assign cnt_inc   = cnt_q + 1'b1;
  assign k_plus2   = {1'b0, k_q} + (NW+1)'(2);
  assign more_segs = (k_plus2 < {1'b0, n_stops_i});

  always_comb begin
    in_ready_o = 1'b0;
    if (state_q == ST_IDLE) begin
      case (in_kind_i)
        KIND_READ:  in_ready_o = sts_i.s1_free;
        KIND_BUILD: in_ready_o = sts_i.s1_empty;
        default:    in_ready_o = 1'b1;
      endcase
    end
  end

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    tail_d       = tail_q;
    k_d          = k_q;
    cmd_o        = '0;
    stop_raddr_o = '0;

    unique case (state_q)
      ST_IDLE: begin
        cmd_o.stop_wr = accept && (in_kind_i == KIND_STOP_WR);
        cmd_o.item_rd = accept && (in_kind_i == KIND_READ);
        if (accept && (in_kind_i == KIND_BUILD)) begin
          cnt_d   = '0;
          state_d = (n_stops_i == '0) ? ST_CLEAR : ST_LD0;
        end
      end
      ST_CLEAR: begin
        cmd_o.tbl_wr      = 1'b1;
        cmd_o.tbl_wr_addr = cnt_q;
        cmd_o.tbl_wr_src  = WSRC_ZERO;
        cnt_d             = cnt_inc;
        if (cnt_q == clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_LD0: begin
        cmd_o.stop_rd = 1'b1;
        state_d       = ST_LD0W;
      end
      ST_LD0W: begin
        cmd_o.load_a = 1'b1;
        cnt_d        = '0;
        state_d      = ST_FILL0;
      end
      ST_FILL0: begin
        cmd_o.tbl_wr      = 1'b1;
        cmd_o.tbl_wr_addr = cnt_q;
        cmd_o.tbl_wr_src  = WSRC_STOP;
        cnt_d             = cnt_inc;
        if (cnt_q == TBL_AW'(sts_i.a_pos)) begin
          // with no rising segment the tail starts just past stop 0
          tail_d = TBL_AW'(sts_i.a_pos) + 1'b1;
          k_d    = '0;
          if (n_stops_i > NW'(1)) begin
            state_d = ST_SEG_RD;
          end else begin
            cnt_d   = TBL_AW'(sts_i.a_pos) + 1'b1;
            state_d = ST_TAIL;
          end
        end
      end
      ST_SEG_RD: begin
        cmd_o.stop_rd = 1'b1;
        stop_raddr_o  = SW'(k_q + 1'b1);
        state_d       = ST_SEG_CHK;
      end
      ST_SEG_CHK: begin
        if (sts_i.rising) begin
          cmd_o.div_start = 1'b1;
          cnt_d           = TBL_AW'(sts_i.a_pos);
          state_d         = ST_DIV;
        end else begin
          cmd_o.load_a = 1'b1;
          k_d          = k_q + 1'b1;
          if (more_segs) begin
            state_d = ST_SEG_RD;
          end else begin
            cnt_d   = tail_q;
            state_d = ST_TAIL;
          end
        end
      end
      ST_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = ST_INTERP;
        end
      end
      ST_INTERP: begin
        cmd_o.tbl_wr      = 1'b1;
        cmd_o.tbl_wr_addr = cnt_q;
        cmd_o.tbl_wr_src  = WSRC_INTERP;
        cmd_o.interp_step = 1'b1;
        cnt_d             = cnt_inc;
        if (cnt_inc == TBL_AW'(sts_i.b_pos)) begin
          tail_d       = TBL_AW'(sts_i.b_pos);
          cmd_o.load_a = 1'b1;
          k_d          = k_q + 1'b1;
          if (more_segs) begin
            state_d = ST_SEG_RD;
          end else begin
            cnt_d   = TBL_AW'(sts_i.b_pos);
            state_d = ST_TAIL;
          end
        end
      end
      ST_TAIL: begin
        if (cnt_q == TBL_AW'(RAMP_ENTRIES)) begin
          cnt_d   = '0;
          state_d = sts_i.reflect ? ST_REFL : ST_IDLE;
        end else begin
          cmd_o.tbl_wr      = 1'b1;
          cmd_o.tbl_wr_addr = cnt_q;
          cmd_o.tbl_wr_src  = WSRC_STOP;
          cnt_d             = cnt_inc;
        end
      end
      ST_REFL: begin
        // read entry 255-j; the datapath writes it to 256+j next cycle
        cmd_o.refl_rd     = 1'b1;
        cmd_o.tbl_rd_addr = TBL_AW'(RAMP_ENTRIES - 1) - cnt_q;
        cnt_d             = cnt_inc;
        if (cnt_q == TBL_AW'(RAMP_ENTRIES - 1)) begin
          state_d = ST_REFL_END;
        end
      end
      ST_REFL_END: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      tail_q  <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      tail_q  <= tail_d;
      k_q     <= k_d;
    end
  end

endmodule

// File: rtl/gradient_color_table_builder.sv
// ----------------------------------------------------------------------------
// gradient_color_table_builder: color ramp table builder
// Loads gradient stops, builds a 256- or 512-entry color ramp and answers
// table reads.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            carries
//  in_ch    in   valid/ready          kind, stop fields, read_index
//  out_ch   out  valid/ready          entry_index and entry color
//  cfg      in   cfg_we_i, no stall   stop_count, reflect_mode, swap_outer
//
//  Reads stream one per cycle while out_ch takes results and no build runs; a
//  result passes the table read stage and the result register after its item
//  is taken. A build holds off all items until done: setup, the table entries
//  written (first fill, interpolation, tail), a stop read per segment and a
//  divide per rising one, and in reflect mode the mirror copy; with no stops it
//  clears 256 or 512 entries. A build waits for the table read stage to drain.
//  Reset leaves the table contents undefined until a build.
// ----------------------------------------------------------------------------
module gradient_color_table_builder #(
  parameter int unsigned MAX_STOPS = gctb_pkg::DEF_MAX_STOPS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  gctb_in_if.sink                         in_ch,
  gctb_out_if.source                      out_ch,
  input  logic                            cfg_we_i,
  input  logic [gctb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gctb_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import gctb_pkg::*;

  localparam int unsigned SW = $clog2(MAX_STOPS);
  localparam int unsigned NW = $clog2(MAX_STOPS + 1);

  dp_cmd_t       cmd;
  dp_sts_t       sts;
  logic [SW-1:0] stop_raddr;
  logic [NW-1:0] n_stops;

  gctb_ctrl #(
    .MAX_STOPS (MAX_STOPS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch.valid),
    .in_kind_i    (in_ch.kind),
    .in_ready_o   (in_ch.ready),
    .sts_i        (sts),
    .n_stops_i    (n_stops),
    .cmd_o        (cmd),
    .stop_raddr_o (stop_raddr)
  );

  gctb_dp #(
    .MAX_STOPS (MAX_STOPS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .stop_slot_i     (in_ch.stop_slot),
    .stop_position_i (in_ch.stop_position),
    .stop_alpha_i    (in_ch.stop_alpha),
    .stop_chan0_i    (in_ch.stop_chan0),
    .stop_chan1_i    (in_ch.stop_chan1),
    .stop_chan2_i    (in_ch.stop_chan2),
    .read_index_i    (in_ch.read_index),
    .cmd_i           (cmd),
    .stop_raddr_i    (stop_raddr),
    .sts_o           (sts),
    .n_stops_o       (n_stops),
    .out_ready_i     (out_ch.ready),
    .out_valid_o     (out_ch.valid),
    .entry_index_o   (out_ch.entry_index),
    .entry_alpha_o   (out_ch.entry_alpha),
    .entry_chan0_o   (out_ch.entry_chan0),
    .entry_chan1_o   (out_ch.entry_chan1),
    .entry_chan2_o   (out_ch.entry_chan2)
  );

endmodule
